### src/sobel_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// Used by sobel_ctrl, sobel_dp and sobel_edge_magnitude.
package sobel_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int PIX_W         = 8;
    localparam int EDGE_W        = 11;
    localparam int FW_W          = 11;
    localparam int FH_W          = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int GRAD_W        = 11;  // signed, |g| <= 1020
    localparam int SQ_W          = 20;  // g*g <= 1040400
    localparam int RAD_W         = 22;  // sum of squares, even width
    localparam int REM_W         = 14;
    localparam int ROOT_STEPS    = RAD_W / 2;
    localparam int ITER_W        = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic              last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic load;       // capture item, read line buffers
        logic eval;       // shift window, update counters, set result
        logic grad;       // register gx, gy
        logic square;     // register gx^2, gy^2
        logic sum;        // register radicand, start root
        logic root_step;  // one result bit of the root
        logic emit;       // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic has_result;
        logic need_root;
        logic root_last;
        logic out_free;
    } t_dp_status;

endpackage

### src/sobel_ctrl.sv
// Sequencer for the Sobel block: one item from accept to result.
// Depends on sobel_pkg for the command and status structs.
module sobel_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sobel_pkg::t_dp_status i_status,
    output sobel_pkg::t_dp_cmd    o_cmd
);
    import sobel_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_GRAD, S_SQUARE, S_SUM, S_ROOT, S_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   accept;

    assign accept     = (r_state == S_IDLE) && i_in_valid && !r_in_stall;
    assign o_in_stall = r_in_stall;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = accept;
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.grad      = (r_state == S_GRAD);
        o_cmd.square    = (r_state == S_SQUARE);
        o_cmd.sum       = (r_state == S_SUM);
        o_cmd.root_step = (r_state == S_ROOT);
        o_cmd.emit      = (r_state == S_EMIT) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state    <= S_EVAL;
                        r_in_stall <= 1'b1;
                    end else begin
                        r_in_stall <= 1'b0;
                    end
                end
                S_EVAL: begin
                    if (!i_status.has_result) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end else if (i_status.need_root) begin
                        r_state <= S_GRAD;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_GRAD:   r_state <= S_SQUARE;
                S_SQUARE: r_state <= S_SUM;
                S_SUM:    r_state <= S_ROOT;
                S_ROOT: begin
                    if (i_status.root_last) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_status.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_stall <= 1'b1;
                end
            endcase
        end
    end

    a_stall_outside_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_in_stall)
        else $error("input not stalled while busy");

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EVAL))
        else $error("accepted item not evaluated");

endmodule

### src/sobel_dp.sv
// Datapath: config registers, line buffers, 3x3 window, position counters,
// gradient, squares and a bit-serial square root, output register.
// Depends on sobel_pkg.
module sobel_dp #(
    parameter int MAX_WIDTH = sobel_pkg::DEF_MAX_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  sobel_pkg::t_in_item                  i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output sobel_pkg::t_out_item                 o_out_item,
    input  sobel_pkg::t_dp_cmd                   i_cmd,
    output sobel_pkg::t_dp_status                o_status
);
    import sobel_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic [WW-1:0]   eff_w;
    logic [FH_W-1:0] eff_h;
    logic            pass;

    logic [PIX_W-1:0] line_above  [MAX_WIDTH];
    logic [PIX_W-1:0] line_middle [MAX_WIDTH];
    logic [PIX_W-1:0] r_above_q;
    logic [PIX_W-1:0] r_mid_q;
    logic [PIX_W-1:0] r_win [3][3];

    logic [AW-1:0]   r_in_col;
    logic [FH_W-1:0] r_in_row;
    logic [AW-1:0]   r_out_col;
    logic [FH_W-1:0] r_out_row;

    logic             r_cmd;
    logic [PIX_W-1:0] r_pix;

    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
    logic [SQ_W-1:0]   r_gx2, r_gy2;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [EDGE_W-1:0] r_root;
    logic [ITER_W-1:0] r_iter;
    logic              r_last;

    logic          restart_in;
    logic [AW-1:0] rd_addr;
    logic          drain_ok, pix_out, in_col_end, out_col_end;
    logic          last_in, last_out, interior;
    logic [REM_W-1:0] rem_sh, trial;
    logic [GRAD_W-1:0] top_s, bot_s, lft_s, rgt_s;

    // Effective geometry: zero counts as one, width saturates at MAX_WIDTH
    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_frame_width);
        end
        eff_h = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
    end

    assign pass       = (32'(eff_w) < 32'd3) || (eff_h < FH_W'(3));
    assign restart_in = (i_in_item.command == CMD_PIXEL) && (r_in_row >= eff_h);
    assign rd_addr    = restart_in ? '0 : r_in_col;

    assign in_col_end  = (32'(r_in_col) == 32'(eff_w) - 32'd1);
    assign out_col_end = (32'(r_out_col) == 32'(eff_w) - 32'd1);
    assign last_in     = in_col_end && (r_in_row == eff_h - FH_W'(1));
    assign last_out    = out_col_end && (r_out_row == eff_h - FH_W'(1));

    // Output lags input by width+1 positions
    assign drain_ok = (r_cmd == CMD_DRAIN) && !pass && (r_in_row >= eff_h)
                      && (r_out_row < eff_h);
    assign pix_out  = (r_cmd == CMD_PIXEL) && !pass
                      && ((r_in_row >= FH_W'(2))
                          || ((r_in_row == FH_W'(1)) && (r_in_col != '0)));
    assign interior = pix_out && (r_out_row != '0) && (r_out_col != '0)
                      && (r_out_row != eff_h - FH_W'(1)) && !out_col_end;

    assign o_status.has_result = drain_ok || pix_out || ((r_cmd == CMD_PIXEL) && pass);
    assign o_status.need_root  = interior;
    assign o_status.root_last  = (r_iter == '0);
    assign o_status.out_free   = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(DEF_FRAME_WIDTH);
            r_frame_height <= FH_W'(DEF_FRAME_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Line buffers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_above_q <= line_above[rd_addr];
        end
        if (i_cmd.eval && (r_cmd == CMD_PIXEL) && !pass) begin
            line_above[r_in_col] <= r_mid_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mid_q <= line_middle[rd_addr];
        end
        if (i_cmd.eval && (r_cmd == CMD_PIXEL) && !pass) begin
            line_middle[r_in_col] <= r_pix;
        end
    end

    // Counters and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_cmd.load && restart_in)) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[r][k] <= '0;
                end
            end
        end else if (i_cmd.eval) begin
            if (r_cmd == CMD_PIXEL) begin
                if (!pass) begin
                    for (int r = 0; r < 3; r++) begin
                        r_win[r][0] <= r_win[r][1];
                        r_win[r][1] <= r_win[r][2];
                    end
                    r_win[0][2] <= r_above_q;
                    r_win[1][2] <= r_mid_q;
                    r_win[2][2] <= r_pix;
                end
                if (in_col_end) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + FH_W'(1);
                end else begin
                    r_in_col <= r_in_col + AW'(1);
                end
            end
            if (drain_ok || pix_out) begin
                if (out_col_end) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + FH_W'(1);
                end else begin
                    r_out_col <= r_out_col + AW'(1);
                end
            end
        end
    end

    // Gradient sums
    assign top_s = GRAD_W'(r_win[0][0]) + GRAD_W'({r_win[0][1], 1'b0}) + GRAD_W'(r_win[0][2]);
    assign bot_s = GRAD_W'(r_win[2][0]) + GRAD_W'({r_win[2][1], 1'b0}) + GRAD_W'(r_win[2][2]);
    assign lft_s = GRAD_W'(r_win[0][0]) + GRAD_W'({r_win[1][0], 1'b0}) + GRAD_W'(r_win[2][0]);
    assign rgt_s = GRAD_W'(r_win[0][2]) + GRAD_W'({r_win[1][2], 1'b0}) + GRAD_W'(r_win[2][2]);

    assign gx_sq = r_gx * r_gx;
    assign gy_sq = r_gy * r_gy;

    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in_item.command;
            r_pix <= i_in_item.pixel_value;
        end
        if (i_cmd.eval) begin
            if (r_cmd == CMD_PIXEL && pass) begin
                r_root <= EDGE_W'(r_pix);
                r_last <= last_in;
            end else begin
                r_root <= '0;
                r_last <= last_out;
            end
        end
        if (i_cmd.grad) begin
            r_gx <= $signed(bot_s - top_s);
            r_gy <= $signed(rgt_s - lft_s);
        end
        if (i_cmd.square) begin
            r_gx2 <= gx_sq[SQ_W-1:0];
            r_gy2 <= gy_sq[SQ_W-1:0];
        end
        if (i_cmd.sum) begin
            r_rad  <= RAD_W'(r_gx2) + RAD_W'(r_gy2);
            r_rem  <= '0;
            r_root <= '0;
            r_iter <= ITER_W'(ROOT_STEPS - 1);
        end
        if (i_cmd.root_step) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_iter <= r_iter - ITER_W'(1);
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[EDGE_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[EDGE_W-2:0], 1'b0};
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_item.edge_value    <= r_root;
            o_out_item.last_of_frame <= r_last;
        end
    end

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!o_out_valid || !i_out_stall))
        else $error("result overwrites an untaken item");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_in_col) < 32'(eff_w)) && (32'(r_out_col) < 32'(eff_w)))
        else $error("column counter beyond row width");

    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_row <= r_in_row)
        else $error("output position ahead of input");

endmodule

### src/sobel_edge_magnitude.sv
// Sobel 3x3 gradient magnitude over a raster pixel stream. Items are taken one
// at a time: the input stays stalled from accept until the item gives no
// result or its result is loaded into the output register, which waits while
// the receiver stalls. An interior pixel first passes through the gradient,
// square and sum registers and the 11-step bit-serial square root.
// Config writes restart the frame.
// Outside passthrough, results appear width+1 positions after their pixel;
// send width+1 drain items after a frame to flush it.
// Top level: sobel_ctrl sequencer plus sobel_dp datapath; uses sobel_pkg.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sobel_pkg::DEF_MAX_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  sobel_pkg::t_in_item              i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output sobel_pkg::t_out_item             o_out_item
);
    import sobel_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    sobel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sobel_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

### verif/sobel_edge_magnitude_tb.sv
// Self-checking testbench for sobel_edge_magnitude: random and directed pixel frames,
// drain items and register writes, with results checked against a built-in predictor.
// Depends on sobel_pkg and the sobel_edge_magnitude RTL.
`timescale 1ns / 1ps

module sobel_edge_magnitude_tb;
    import sobel_pkg::*;

    localparam int MAXW      = DEF_MAX_WIDTH;
    localparam int SETTLE    = 60;
    localparam int CYC_LIMIT = 3000000;

    // Edge magnitude predictor plus queue of expected output items
    class edge_scoreboard;
        int unsigned  fw, fh;
        byte unsigned row_top[MAXW];
        byte unsigned row_mid[MAXW];
        byte unsigned win[3][3];
        int unsigned  col, row, outpos;
        t_out_item    edge_q[$];
        int           errors;

        function new();
            fw = DEF_FRAME_WIDTH;
            fh = DEF_FRAME_HEIGHT;
            foreach (row_top[i]) begin
                row_top[i] = 0;
                row_mid[i] = 0;
            end
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (win[r, k]) win[r][k] = 0;
            col = 0;
            row = 0;
            outpos = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_FRAME_WIDTH) fw = val[FW_W-1:0];
            else fh = val[FH_W-1:0];
            restart();
        endfunction

        function int unsigned int_sqrt(int unsigned v);
            int unsigned r;
            r = 0;
            while ((r + 1) * (r + 1) <= v) r++;
            return r;
        endfunction

        function void note_input(t_in_item it);
            int unsigned w, h, total, c, p, q, val;
            int gx, gy;
            bit pass;
            t_out_item res;
            w = (fw == 0) ? 1 : fw;
            if (w > MAXW) w = MAXW;
            h = (fh == 0) ? 1 : fh;
            total = w * h;
            pass = (w < 3) || (h < 3);
            if (it.command == CMD_DRAIN) begin
                if (pass || row < h || outpos >= total) return;
                res.edge_value = '0;
                res.last_of_frame = (outpos == total - 1);
                outpos++;
                edge_q.push_back(res);
                return;
            end
            if (row >= h) restart();
            c = col;
            p = row * w + c;
            if (pass) begin
                res.edge_value = EDGE_W'(it.pixel_value);
                res.last_of_frame = (p == total - 1);
                outpos = p + 1;
                edge_q.push_back(res);
            end else begin
                for (int r = 0; r < 3; r++) begin
                    win[r][0] = win[r][1];
                    win[r][1] = win[r][2];
                end
                win[0][2] = row_top[c];
                win[1][2] = row_mid[c];
                win[2][2] = it.pixel_value;
                row_top[c] = row_mid[c];
                row_mid[c] = it.pixel_value;
                if (p >= w + 1) begin
                    q = outpos;
                    val = 0;
                    // interior only: not first/last row or column
                    if (q / w != 0 && q % w != 0 && q / w != h - 1 && q % w != w - 1) begin
                        gx = (win[2][0] + 2 * win[2][1] + win[2][2])
                           - (win[0][0] + 2 * win[0][1] + win[0][2]);
                        gy = (win[0][2] + 2 * win[1][2] + win[2][2])
                           - (win[0][0] + 2 * win[1][0] + win[2][0]);
                        val = int_sqrt(gx * gx + gy * gy);
                    end
                    res.edge_value = val[EDGE_W-1:0];
                    res.last_of_frame = (q == total - 1);
                    outpos = q + 1;
                    edge_q.push_back(res);
                end
            end
            col = c + 1;
            if (col >= w) begin
                col = 0;
                row++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (edge_q.size() == 0) begin
                $error("unexpected output item: edge_value %0d last_of_frame %0d",
                       got.edge_value, got.last_of_frame);
                errors++;
                return;
            end
            want = edge_q.pop_front();
            if (got.edge_value !== want.edge_value) begin
                $error("edge_value: expected %0d actual %0d", want.edge_value, got.edge_value);
                errors++;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
                $error("last_of_frame: expected %0d actual %0d",
                       want.last_of_frame, got.last_of_frame);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;

    edge_scoreboard sb = new();
    int  cycles = 0;
    int  items_sent = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;

    sobel_edge_magnitude dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);

    // receiver: random stall per item, plus one long hold-off on request
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end
            n = no_idle ? 0 : $urandom_range(0, 15);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    task automatic send_item(logic cmd, logic [PIX_W-1:0] pix);
        int n;
        t_in_item it;
        n = no_idle ? 0 : $urandom_range(0, 15);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        it.command = cmd;
        it.pixel_value = pix;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        items_sent++;
    endtask

    // wait for every expected item, then let in-flight work settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.edge_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[FW_W-1:0] = w[FW_W-1:0];  // upper bits are ignored by the block
        write_reg(CFG_FRAME_WIDTH, d);
        write_reg(CFG_FRAME_HEIGHT, h[CFG_DATA_W-1:0]);
    endtask

    // npix pixels, then ndrain drain items; occasional stray drains mid-frame
    task automatic frame(int unsigned npix, int unsigned ndrain, int style);
        logic [PIX_W-1:0] px;
        for (int unsigned i = 0; i < npix; i++) begin
            case (style)
                1: px = (i % 2) ? 8'hFF : 8'h00;
                2: px = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
                default: px = PIX_W'($urandom);
            endcase
            if ($urandom_range(0, 29) == 0) send_item(CMD_DRAIN, PIX_W'($urandom));
            send_item(CMD_PIXEL, px);
        end
        for (int unsigned i = 0; i < ndrain; i++) send_item(CMD_DRAIN, PIX_W'($urandom));
    endtask

    initial begin
        int unsigned w, h, weff, heff, nframes, sel;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        frame(3, 1, 0);                 // reset size, partial row, early drain ignored
        set_size(3, 3);
        frame(9, 5, 1);                 // checkerboard, one extra drain past the end
        frame(9, 4, 2);
        send_item(CMD_PIXEL, 8'hFF);    // new frame after complete one
        set_size(1, 5);
        frame(5, 1, 1);                 // passthrough, drain gives nothing
        set_size(0, 0);
        frame(2, 1, 1);
        set_size(2047, 1);              // width saturates, single row passthrough
        frame(3, 0, 1);
        set_size(2, 65535);
        frame(4, 0, 2);

        // random part
        while (items_sent < 1000) begin
            sel = $urandom_range(0, 19);
            if (sel < 13) begin
                w = $urandom_range(3, 9);
                h = $urandom_range(3, 6);
            end else if (sel < 17) begin
                w = $urandom_range(0, 4);
                h = $urandom_range(0, 3);
            end else if (sel < 19) begin
                w = $urandom_range(3, 40);
                h = 65535 - $urandom_range(0, 1);
            end else begin
                w = $urandom_range(1, 2);
                h = $urandom_range(60000, 65535);
            end
            set_size(w, h);
            weff = (w == 0) ? 1 : w;
            heff = (h == 0) ? 1 : h;
            no_idle = ($urandom_range(0, 3) == 0);
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                if (heff > 100) frame($urandom_range(1, 3 * weff), 2, $urandom_range(0, 2));
                else if ($urandom_range(0, 4) == 0)
                    frame(weff * heff, $urandom_range(0, weff), $urandom_range(0, 2));
                else frame(weff * heff, weff + 1 + $urandom_range(0, 2), $urandom_range(0, 2));
            end
            no_idle = 1'b0;
        end

        // wide frame, with a long receiver hold-off so the block backs up
        set_size(40, 3);
        hold_req = 1'b1;
        frame(3 * 40, 40 + 1, 0);
        set_size(4, 3);
        frame(12, 5, 2);

        wait_idle();
        if (sb.errors == 0 && sb.edge_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
